// ===== rtl/bcm_pkg.sv =====
package bcm_pkg;

    // window and search limits
    localparam int WINDOW_DEPTH     = 16;
    localparam int MAX_DETECT_STEPS = 10;

    // field widths
    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 18;
    localparam int OFFSET_W   = 14;
    localparam int CELL_MV_W  = 13;
    localparam int FLOOR_W    = 16;
    localparam int MV_W       = 16;
    localparam int CELLS_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    // window store and running sum
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = SAMPLE_W + SLOT_W;

    // sum / WINDOW_DEPTH as multiply by rounded-up reciprocal, exact over SUM_W bits
    localparam int DIV_SHIFT = SUM_W + SLOT_W;
    localparam int DIV_MUL_W = SUM_W + 1;
    localparam int DIV_PROD_W = SUM_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    // Q16 scaling
    localparam int GAIN_FRAC_W  = 16;
    localparam int SCALE_PROD_W = SAMPLE_W + GAIN_W;
    localparam int SCALED_W     = SCALE_PROD_W - GAIN_FRAC_W;
    localparam int MV_SUM_W     = SCALED_W + 2;

    // cell count search
    localparam int N_W         = $clog2(MAX_DETECT_STEPS + 1);
    localparam int STEP_PROD_W = N_W + CELL_MV_W;
    localparam int STEP_CMP_W  = (STEP_PROD_W > MV_W) ? STEP_PROD_W : MV_W;
    localparam int LOW_PROD_W  = CELLS_W + CELL_MV_W;

    // register reset values
    localparam logic [GAIN_W-1:0]    GAIN_RST   = GAIN_W'(52800);
    localparam logic [OFFSET_W-1:0]  OFFSET_RST = '0;
    localparam logic [CELL_MV_W-1:0] FULL_RST   = CELL_MV_W'(4200);
    localparam logic [CELL_MV_W-1:0] EMPTY_RST  = CELL_MV_W'(3000);
    localparam logic [CELL_MV_W-1:0] LOW_RST    = CELL_MV_W'(3300);
    localparam logic [FLOOR_W-1:0]   FLOOR_RST  = FLOOR_W'(5000);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DETECT = 2'd1,
        CMD_CHECK  = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        DET_DONE  = 2'd0,
        DET_FLOOR = 2'd1,
        DET_ZERO  = 2'd2
    } det_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTS_GAIN   = 3'd0,
        REG_VOLTS_OFFSET = 3'd1,
        REG_CELL_FULL    = 3'd2,
        REG_CELL_EMPTY   = 3'd3,
        REG_CELL_LOW     = 3'd4,
        REG_DETECT_FLOOR = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFSET,
        ST_CLASSIFY,
        ST_STEP,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic load_in;
        logic scale;
        logic push;
        logic offset;
        logic classify;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_push;
        logic is_detect;
        logic search;
        logic step_stop;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/bcm_ram.sv =====
module bcm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bcm_ctrl.sv =====
module bcm_ctrl
    import bcm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_SCALE;
                end
            end
            ST_SCALE: begin
                dp_cmd.scale = 1'b1;
                dp_cmd.push  = dp_status.is_push;
                state_next   = ST_OFFSET;
            end
            ST_OFFSET: begin
                dp_cmd.offset = 1'b1;
                state_next    = dp_status.is_detect ? ST_CLASSIFY : ST_CHECK;
            end
            ST_CLASSIFY: begin
                dp_cmd.classify = 1'b1;
                state_next      = dp_status.search ? ST_STEP : ST_CHECK;
            end
            ST_STEP: begin
                dp_cmd.step = 1'b1;
                if (dp_status.step_stop) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // hold until the output register can take the result
                if (dp_status.out_free) begin
                    dp_cmd.emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bcm_datapath.sv =====
module bcm_datapath
    import bcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // configuration
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [CELL_MV_W-1:0]       full_reg;
    logic [CELL_MV_W-1:0]       empty_reg;
    logic [CELL_MV_W-1:0]       low_reg;
    logic [FLOOR_W-1:0]         floor_reg;

    // window state
    logic [SUM_W-1:0]        sum_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic                    old_valid_reg;
    logic [SAMPLE_W-1:0]     ring_rdata;
    logic [SAMPLE_W-1:0]     old_sample;

    // request and working registers
    logic [CMD_W-1:0]    cmd_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [N_W-1:0]      n_reg;
    logic [N_W-1:0]      step_cnt_reg;
    logic [CELLS_W-1:0]  cell_count_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [DIV_PROD_W-1:0]   div_prod;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic signed [MV_SUM_W-1:0] mv_sum;
    logic [MV_W-1:0]         mv_next;
    logic [STEP_CMP_W-1:0]   full_prod;
    logic [STEP_CMP_W-1:0]   empty_prod;
    logic [STEP_CMP_W-1:0]   mv_cmp;
    logic                    step_up;
    logic                    step_down;
    logic [N_W-1:0]          n_next;
    logic [LOW_PROD_W-1:0]   low_prod;
    logic                    battery_ok;
    logic [SLOT_W-1:0]       slot_next;

    bcm_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (dp_cmd.push),
        .waddr(slot_reg),
        .wdata(sample_reg),
        .raddr(slot_reg),
        .rdata(ring_rdata)
    );

    // entry never pushed reads as zero
    assign old_sample = old_valid_reg ? ring_rdata : '0;
    assign slot_next  = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    assign div_prod   = DIV_PROD_W'(sum_reg) * DIV_PROD_W'(DIV_MUL);
    assign scale_prod = SCALE_PROD_W'(avg_reg) * SCALE_PROD_W'(gain_reg);

    // never exceeds 65535 here, so only the low side clamps
    assign mv_sum  = $signed({2'b00, scaled_reg}) + MV_SUM_W'(offset_reg);
    assign mv_next = mv_sum[MV_SUM_W-1] ? '0 : MV_W'($unsigned(mv_sum));

    assign full_prod  = STEP_CMP_W'(STEP_PROD_W'(n_reg) * STEP_PROD_W'(full_reg));
    assign empty_prod = STEP_CMP_W'(STEP_PROD_W'(n_reg) * STEP_PROD_W'(empty_reg));
    assign mv_cmp     = STEP_CMP_W'(mv_reg);
    assign step_up    = mv_cmp > full_prod;
    assign step_down  = !step_up && (mv_cmp < empty_prod) && (n_reg != '0);
    assign n_next     = step_up ? n_reg + 1'b1 : (step_down ? n_reg - 1'b1 : n_reg);

    assign low_prod   = LOW_PROD_W'(cell_count_reg) * LOW_PROD_W'(low_reg);
    assign battery_ok = !((cell_count_reg != '0) && (LOW_PROD_W'(mv_reg) <= low_prod));

    assign dp_status.is_push   = (cmd_reg == CMD_PUSH);
    assign dp_status.is_detect = (cmd_reg == CMD_DETECT);
    assign dp_status.search    = (mv_reg != '0) && (mv_reg > floor_reg);
    assign dp_status.step_stop = !(step_up || step_down)
                               || (step_cnt_reg == N_W'(MAX_DETECT_STEPS - 1));
    assign dp_status.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RST;
            offset_reg <= OFFSET_RST;
            full_reg   <= FULL_RST;
            empty_reg  <= EMPTY_RST;
            low_reg    <= LOW_RST;
            floor_reg  <= FLOOR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_VOLTS_GAIN:   gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_VOLTS_OFFSET: offset_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
                REG_CELL_FULL:    full_reg   <= cfg_wdata[CELL_MV_W-1:0];
                REG_CELL_EMPTY:   empty_reg  <= cfg_wdata[CELL_MV_W-1:0];
                REG_CELL_LOW:     low_reg    <= cfg_wdata[CELL_MV_W-1:0];
                REG_DETECT_FLOOR: floor_reg  <= cfg_wdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            slot_reg       <= '0;
            valid_reg      <= '0;
            cell_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (dp_cmd.push) begin
                sum_reg             <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
            end
            if (dp_cmd.classify && !dp_status.search) begin
                cell_count_reg <= '0;
            end
            if (dp_cmd.step && dp_status.step_stop) begin
                cell_count_reg <= CELLS_W'(n_next);
            end
            if (dp_cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            cmd_reg       <= s_tuser;
            sample_reg    <= s_tdata[SAMPLE_W-1:0];
            // estimate always from the window before this request
            avg_reg       <= div_prod[DIV_SHIFT +: SAMPLE_W];
            old_valid_reg <= valid_reg[slot_reg];
            status_reg    <= DET_DONE;
        end
        if (dp_cmd.scale) begin
            scaled_reg <= scale_prod[GAIN_FRAC_W +: SCALED_W];
        end
        if (dp_cmd.offset) begin
            mv_reg <= mv_next;
        end
        if (dp_cmd.classify) begin
            n_reg        <= '0;
            step_cnt_reg <= '0;
            if (mv_reg == '0) begin
                status_reg <= DET_ZERO;
            end else if (!dp_status.search) begin
                status_reg <= DET_FLOOR;
            end
        end
        if (dp_cmd.step) begin
            n_reg        <= n_next;
            step_cnt_reg <= step_cnt_reg + 1'b1;
        end
        if (dp_cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({status_reg, battery_ok, cell_count_reg, mv_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/battery_cell_count_monitor.sv =====
// Sequence: push and check go through scale, offset and check; a detect that stops at the
// floor or a zero reading adds classify, and a detect whose search runs k steps (k = 1..10,
// one step per cycle) adds classify and the step search. The result waits in check until
// the output register is free; no new request is taken until it has been loaded there.
// Reset (aresetn low, synchronous): window emptied, sum, slot and cell count cleared,
// registers back to defaults, output empty. The window needs no clearing pass.
module battery_cell_count_monitor
    import bcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [15:0] voltage_mv, [19:16] cells,
                                             // [20] battery_ok, [22:21] detect_status,
                                             // [23] zero
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    bcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_status(dp_status),
        .dp_cmd   (dp_cmd)
    );

    bcm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .dp_cmd   (dp_cmd),
        .dp_status(dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/bcm_reading_checker.sv =====
module bcm_reading_checker
    import bcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    failures,
    output int                    readings_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic                pad;
        det_status_t         status;
        logic                ok;
        logic [CELLS_W-1:0]  cells;
        logic [MV_W-1:0]     mv;
    } reading_t;

    // shadow register file
    logic [GAIN_W-1:0]           volts_gain;
    logic signed [OFFSET_W-1:0]  volts_offset;
    logic [CELL_MV_W-1:0]        cell_full;
    logic [CELL_MV_W-1:0]        cell_empty;
    logic [CELL_MV_W-1:0]        cell_low;
    logic [FLOOR_W-1:0]          floor_mv;

    // shadow window and cell count
    logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
    int unsigned         win_total;
    int                  write_slot;
    logic [CELLS_W-1:0]  cell_count;

    reading_t expected_readings [$];
    reading_t got;
    reading_t want;
    int       errs;
    int       seen;

    function automatic reading_t predict_reading(input logic [CMD_W-1:0] cmd,
                                                 input logic [SAMPLE_W-1:0] smp);
        longint   scaled;
        int       mv;
        int       n;
        int       k;
        reading_t r;
        // voltage always comes from the window as it stood before this request
        scaled = (longint'(win_total / WINDOW_DEPTH) * longint'(volts_gain)) >> 16;
        mv = int'(scaled) + int'(volts_offset);
        if (mv < 0)
            mv = 0;
        if (mv > 65535)
            mv = 65535;
        r.pad = 1'b0;
        r.status = DET_DONE;
        case (cmd)
            CMD_PUSH: begin
                win_total = win_total - ring[write_slot] + smp;
                ring[write_slot] = smp;
                write_slot = (write_slot == WINDOW_DEPTH - 1) ? 0 : write_slot + 1;
            end
            CMD_DETECT: begin
                cell_count = '0;
                if (mv == 0) begin
                    r.status = DET_ZERO;
                end else if (mv <= int'(floor_mv)) begin
                    r.status = DET_FLOOR;
                end else begin
                    n = 0;
                    for (k = 0; k < MAX_DETECT_STEPS; k++) begin
                        if (mv > n * int'(cell_full))
                            n++;
                        else if (mv < n * int'(cell_empty) && n > 0)
                            n--;
                        else
                            break;
                    end
                    cell_count = n[CELLS_W-1:0];
                end
            end
            default: ;  // check and the unused code leave state alone
        endcase
        r.mv = mv[MV_W-1:0];
        r.cells = cell_count;
        r.ok = !(cell_count != 0 && mv <= int'(cell_count) * int'(cell_low));
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            volts_gain = GAIN_RST;
            volts_offset = OFFSET_RST;
            cell_full = FULL_RST;
            cell_empty = EMPTY_RST;
            cell_low = LOW_RST;
            floor_mv = FLOOR_RST;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                ring[i] = '0;
            win_total = 0;
            write_slot = 0;
            cell_count = '0;
            expected_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = reading_t'(m_tdata);
                seen++;
                if (expected_readings.size() == 0) begin
                    $display("%0t: reading with no request outstanding, got %h", $time, m_tdata);
                    errs++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.mv != want.mv) begin
                        $display("%0t: voltage_mv expected %0d got %0d", $time, want.mv, got.mv);
                        errs++;
                    end
                    if (got.cells != want.cells) begin
                        $display("%0t: cells expected %0d got %0d", $time, want.cells,
                                 got.cells);
                        errs++;
                    end
                    if (got.ok != want.ok) begin
                        $display("%0t: battery_ok expected %0d got %0d", $time, want.ok, got.ok);
                        errs++;
                    end
                    if (got.status != want.status) begin
                        $display("%0t: detect_status expected %0d got %0d", $time,
                                 want.status, got.status);
                        errs++;
                    end
                    if (got.pad != 1'b0) begin
                        $display("%0t: pad bit expected 0 got %0d", $time, got.pad);
                        errs++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_VOLTS_GAIN:   volts_gain = cfg_wdata[GAIN_W-1:0];
                    REG_VOLTS_OFFSET: volts_offset = cfg_wdata[OFFSET_W-1:0];
                    REG_CELL_FULL:    cell_full = cfg_wdata[CELL_MV_W-1:0];
                    REG_CELL_EMPTY:   cell_empty = cfg_wdata[CELL_MV_W-1:0];
                    REG_CELL_LOW:     cell_low = cfg_wdata[CELL_MV_W-1:0];
                    REG_DETECT_FLOOR: floor_mv = cfg_wdata[FLOOR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tuser, s_tdata[SAMPLE_W-1:0]));
        end
        failures <= errs;
        readings_seen <= seen;
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import bcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSED} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [11:0] sample, [15:12] zero
    logic [CMD_W-1:0]      s_tuser;   // [1:0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [15:0] voltage_mv, [19:16] cells, [20] battery_ok,
                                      // [22:21] detect_status, [23] zero
    int failures;
    int readings_seen;

    int requests_sent;
    int per_cmd [4];
    int settings_used;
    int burst_left;
    int level;
    int cycles;
    rx_mode_t rx_mode;
    int rx_left;

    battery_cell_count_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bcm_reading_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .failures      (failures),
        .readings_seen (readings_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver back-pressure: a new mode is drawn each time rx_left runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 240);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= (rx_left % 11) < 4;
        endcase
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, smp};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        per_cmd[cmd]++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (readings_seen != requests_sent)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_limits(input int gain, input int offset, input int full,
                                  input int empty, input int low, input int floor_mv);
        write_reg(REG_VOLTS_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_VOLTS_OFFSET, CFG_DATA_W'(offset & ((1 << OFFSET_W) - 1)));
        write_reg(REG_CELL_FULL, CFG_DATA_W'(full));
        write_reg(REG_CELL_EMPTY, CFG_DATA_W'(empty));
        write_reg(REG_CELL_LOW, CFG_DATA_W'(low));
        write_reg(REG_DETECT_FLOOR, CFG_DATA_W'(floor_mv));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // samples cluster round a drifting level so the window average means something
    task automatic random_traffic(input int count);
        int pick;
        int smp;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                cmd = CMD_PUSH;
            else if (pick < 80)
                cmd = CMD_DETECT;
            else if (pick < 95)
                cmd = CMD_CHECK;
            else
                cmd = CMD_SPARE;
            if ($urandom_range(0, 15) == 0)
                level = $urandom_range(0, 4095);
            if ($urandom_range(0, 9) == 0) begin
                smp = $urandom_range(0, 4095);
            end else begin
                smp = level + $urandom_range(0, 128) - 64;
                if (smp < 0)
                    smp = 0;
                if (smp > 4095)
                    smp = 4095;
            end
            send_request(cmd, SAMPLE_W'(smp));
        end
    endtask

    initial begin
        int full;
        int empty;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_VOLTS_GAIN;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_PUSH;
        m_tready = 1'b0;
        level = 2048;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: zero reading on an empty window, spare code, floor case
        send_request(CMD_DETECT, 12'hFFF);
        send_request(CMD_CHECK, 12'h000);
        send_request(CMD_SPARE, 12'hABC);
        send_request(CMD_PUSH, 12'hFFF);
        send_request(CMD_PUSH, 12'hFFF);
        send_request(CMD_PUSH, 12'h000);
        send_request(CMD_PUSH, 12'hAAA);
        send_request(CMD_PUSH, 12'h555);
        send_request(CMD_DETECT, 12'h000);
        send_request(CMD_CHECK, 12'hFFF);
        wait_idle();

        // high gain, tight cell bounds: search runs the full ten steps, low battery
        program_limits(262143, 0, 1000, 800, 8191, 0);
        repeat (8) send_request(CMD_PUSH, 12'hFFF);
        send_request(CMD_DETECT, 12'h000);
        send_request(CMD_CHECK, 12'h000);
        send_request(CMD_SPARE, 12'h000);
        send_request(CMD_PUSH, 12'h000);
        wait_idle();

        // every register at its top end, then its bottom end, then a mix of the two
        program_limits(262143, 8191, 8191, 8191, 8191, 65535);
        random_traffic(40);
        wait_idle();
        program_limits(0, -8192, 0, 0, 0, 0);
        random_traffic(40);
        wait_idle();
        program_limits(262143, 8191, 0, 8191, 8191, 0);
        random_traffic(40);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            full = $urandom_range(500, 4500);
            empty = $urandom_range(full / 2, full + 1000);
            program_limits($urandom_range(100000, 262143), $urandom_range(0, 16383) - 8192,
                           full, empty, $urandom_range(empty / 2, full),
                           $urandom_range(0, 9000));
            random_traffic(80);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests (%0d push, %0d detect, %0d check, %0d spare code)",
                 requests_sent, per_cmd[CMD_PUSH], per_cmd[CMD_DETECT], per_cmd[CMD_CHECK],
                 per_cmd[CMD_SPARE]);
        $display("under %0d settings, %0d readings compared, %0d mismatches",
                 settings_used, readings_seen, failures);
        if (failures == 0 && readings_seen == requests_sent) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bcm_pkg.sv
rtl/bcm_ram.sv
rtl/bcm_ctrl.sv
rtl/bcm_datapath.sv
rtl/battery_cell_count_monitor.sv
sim/bcm_reading_checker.sv
sim/tb.sv
